/* rtl/rapb_pkg.sv */
// ----------------------------------------------------------------------------
// rapb_pkg
// Shared types and constants of the register access permission bitmap unit.
// ----------------------------------------------------------------------------
package rapb_pkg;

  localparam int MAX_MAP_BYTES = 8192;
  localparam int WORD_COUNT    = MAX_MAP_BYTES / 4;
  localparam int MAP_CAP_BYTES = (MAX_MAP_BYTES / 4) * 4;
  localparam int MAP_BITS_MAX  = MAP_CAP_BYTES * 8;
  localparam int ADDR_W        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W         = ADDR_W + 5;
  localparam int MBITS_W       = $clog2(MAP_BITS_MAX + 1);

  localparam int CFG_W  = 14;
  localparam int OFF_W  = 24;
  localparam int SIZE_W = 25;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_ARG = 2'd1;
  localparam logic [1:0] STAT_NO_MAP  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             empty;
    logic [BIT_W-1:0] first;
    logic [BIT_W-1:0] last;
  } chk_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wr_data;
  } mem_req_t;

endpackage

/* rtl/rapb_check.sv */
// ----------------------------------------------------------------------------
// rapb_check
// Argument check of one word: alignment, map presence and range bounds.
// ----------------------------------------------------------------------------
module rapb_check (
  input  logic                         cmd,
  input  logic [rapb_pkg::OFF_W-1:0]   byte_offset,
  input  logic [rapb_pkg::SIZE_W-1:0]  byte_size,
  input  logic [rapb_pkg::MBITS_W-1:0] map_bits,
  output rapb_pkg::chk_t               chk
);
  import rapb_pkg::*;

  logic [OFF_W-3:0]  first;
  logic [SIZE_W-3:0] count;
  logic [OFF_W-1:0]  range_end;
  logic [OFF_W-1:0]  map_ext;
  logic              misaligned;

  assign first      = byte_offset[OFF_W-1:2];
  assign count      = byte_size[SIZE_W-1:2];
  assign range_end  = OFF_W'(first) + OFF_W'(count);
  assign map_ext    = OFF_W'(map_bits);
  assign misaligned = (byte_offset[1:0] != 2'b00);

  always_comb begin
    chk.first = BIT_W'(first);
    chk.last  = BIT_W'(range_end - OFF_W'(1));
    chk.empty = (count == '0);
    priority if (map_bits == '0) begin
      chk.status = STAT_NO_MAP;
    end else if (cmd == CMD_SET) begin
      if (misaligned || (byte_size[1:0] != 2'b00) || (OFF_W'(first) >= map_ext) ||
          (range_end > map_ext)) begin
        chk.status = STAT_BAD_ARG;
      end else begin
        chk.status = STAT_OK;
      end
    end else begin
      if (misaligned || (OFF_W'(first) >= map_ext)) begin
        chk.status = STAT_BAD_ARG;
      end else begin
        chk.status = STAT_OK;
      end
    end
  end

endmodule

/* rtl/rapb_mem.sv */
// ----------------------------------------------------------------------------
// rapb_mem
// Permission word store, one port, registered read data.
// ----------------------------------------------------------------------------
module rapb_mem (
  input  logic               clk,
  input  rapb_pkg::mem_req_t req,
  output logic [31:0]        rd_data
);
  import rapb_pkg::*;

  logic [31:0] words [WORD_COUNT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      words[req.addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= words[req.addr];
    end
  end

endmodule

/* rtl/rapb_seq.sv */
// ----------------------------------------------------------------------------
// rapb_seq
// Sequencer: clearing pass, then per-word read-modify-write; tests only read.
// ----------------------------------------------------------------------------
module rapb_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic               allow,
  input  rapb_pkg::chk_t     chk,
  output rapb_pkg::mem_req_t mem_req,
  input  logic [31:0]        rd_data,
  output logic               res_valid,
  input  logic               res_take,
  output logic [1:0]         res_status,
  output logic               res_allowed
);
  import rapb_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] cur_word;
  logic [ADDR_W-1:0] first_word;
  logic [ADDR_W-1:0] last_word;
  logic [4:0]        first_bit;
  logic [4:0]        last_bit;
  logic              lat_cmd;
  logic              lat_allow;
  logic [31:0]       lo_mask;
  logic [31:0]       hi_mask;
  logic [31:0]       mask;
  logic [31:0]       merged;

  // bits of the range that fall into the current word
  assign lo_mask = (cur_word == first_word) ? (32'hffff_ffff << first_bit) : 32'hffff_ffff;
  assign hi_mask = (cur_word == last_word) ? (32'hffff_ffff >> (5'd31 - last_bit))
                                           : 32'hffff_ffff;
  assign mask    = lo_mask & hi_mask;
  assign merged  = lat_allow ? (rd_data | mask) : (rd_data & ~mask);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (cur_word == ADDR_W'(WORD_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if ((chk.status != STAT_OK) || ((cmd == CMD_SET) && chk.empty)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: state_next = ST_WRITE;
      ST_WRITE: begin
        if ((lat_cmd == CMD_TEST) || (cur_word == last_word)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (res_take) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    res_valid       = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.addr    = cur_word;
    mem_req.wr_data = merged;
    unique case (state)
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_data = '0;
      end
      ST_IDLE:  in_stall = 1'b0;
      ST_READ:  mem_req.rd_en = 1'b1;
      ST_WRITE: mem_req.wr_en = (lat_cmd == CMD_SET);
      ST_DONE:  res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cur_word <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: cur_word <= cur_word + ADDR_W'(1);
        ST_IDLE: begin
          if (in_valid) cur_word <= chk.first[BIT_W-1:5];
        end
        ST_WRITE: begin
          if (lat_cmd == CMD_SET) cur_word <= cur_word + ADDR_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_valid) begin
      lat_cmd     <= cmd;
      lat_allow   <= allow;
      first_word  <= chk.first[BIT_W-1:5];
      first_bit   <= chk.first[4:0];
      last_word   <= chk.last[BIT_W-1:5];
      last_bit    <= chk.last[4:0];
      res_status  <= chk.status;
      res_allowed <= 1'b0;
    end else if ((state == ST_WRITE) && (lat_cmd == CMD_TEST)) begin
      res_allowed <= rd_data[first_bit];
    end
  end

endmodule

/* rtl/register_access_permission_bitmap_unit.sv */
// ----------------------------------------------------------------------------
// register_access_permission_bitmap_unit
// One permission bit per 32-bit register; range set and single-register test.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_wr_en              cfg_wr_data (map size in bytes)
//   in       in         in_valid / in_stall    cmd, byte_offset, byte_size, allow
//   out      out        out_valid / out_stall  status, allowed
//
// after reset all 2048 words of the store are cleared one word a cycle with in_stall high
// test: per word the steps are accept, read, bit select and hand-off to the output register
// set: accept, then one read-modify-write per permission word touched on the
// single memory port, then hand-off; rejected or empty words go from accept to hand-off
// the output register holds a result under out_stall while the next word is worked
// ----------------------------------------------------------------------------
module register_access_permission_bitmap_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [rapb_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [rapb_pkg::OFF_W-1:0]   byte_offset,
  input  logic [rapb_pkg::SIZE_W-1:0]  byte_size,
  input  logic                         allow,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic                         allowed
);
  import rapb_pkg::*;

  logic [MBITS_W-1:0] map_bits;
  logic [31:0]        size_rnd;
  logic [31:0]        size_sat;
  chk_t               chk;
  mem_req_t           mem_req;
  logic [31:0]        rd_data;
  logic               res_valid;
  logic               res_take;
  logic [1:0]         res_status;
  logic               res_allowed;

  // round up to a whole permission word, saturate at the store size, keep as a bit count
  assign size_rnd = (32'(cfg_wr_data) + 32'd3) & ~32'd3;
  assign size_sat = (size_rnd > 32'(MAP_CAP_BYTES)) ? 32'(MAP_CAP_BYTES) : size_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_bits <= '0;
    end else if (cfg_wr_en) begin
      map_bits <= MBITS_W'(size_sat << 3);
    end
  end

  rapb_check u_check (
    .cmd         (cmd),
    .byte_offset (byte_offset),
    .byte_size   (byte_size),
    .map_bits    (map_bits),
    .chk         (chk)
  );

  rapb_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .allow       (allow),
    .chk         (chk),
    .mem_req     (mem_req),
    .rd_data     (rd_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_status  (res_status),
    .res_allowed (res_allowed)
  );

  rapb_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      status  <= res_status;
      allowed <= res_allowed;
    end
  end

endmodule
